@@ design/touch_event_calibrate_debounce_assert.svh @@
// Assertion macros shared by the touch event calibration block.
`ifndef TOUCH_EVENT_CALIBRATE_DEBOUNCE_ASSERT_SVH
`define TOUCH_EVENT_CALIBRATE_DEBOUNCE_ASSERT_SVH

// The condition implies the expression in the same cycle.
`define TECD_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("tecd: same-cycle check failed");

// The condition implies the expression in the next cycle.
`define TECD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("tecd: next-cycle check failed");

`endif

@@ design/tecd_pkg.sv @@
// Package with types, constants and field positions of the touch event block.
`default_nettype none

package tecd_pkg;

   localparam int RAW_BITS  = 16;
   localparam int TIME_BITS = 32;

   localparam int SAMPLE_W   = 16;
   localparam int MS_W       = 32;
   localparam int EVENT_LSB  = SAMPLE_W;
   localparam int NOW_LSB    = SAMPLE_W + MS_W;
   localparam int REQ_DATA_W = SAMPLE_W + 2 * MS_W;
   localparam int CMD_W      = 2;

   localparam int COORD_W    = 16;
   localparam int RSP_DATA_W = 2 * COORD_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COEF_W     = 32;
   localparam int DIV_W      = 31;
   localparam int THR_W      = 8;

   localparam int PROD_W = COEF_W + RAW_BITS + 1;
   localparam int ACC_W  = PROD_W + 1;
   localparam int QUO_W  = COORD_W;
   localparam int REM_W  = DIV_W + QUO_W;
   localparam int CNT_W  = $clog2(QUO_W);
   localparam int DIST_W = COORD_W + 2;

   localparam int STALE_MS    = 1000;
   localparam int DEBOUNCE_MS = 70;

   localparam logic signed [COEF_W-1:0] RST_CAL_XX  = 32'sd13962;
   localparam logic signed [COEF_W-1:0] RST_CAL_XY  = 32'sd114;
   localparam logic signed [COEF_W-1:0] RST_CAL_XO  = -32'sd2429380;
   localparam logic signed [COEF_W-1:0] RST_CAL_YX  = 32'sd255;
   localparam logic signed [COEF_W-1:0] RST_CAL_YY  = 32'sd8679;
   localparam logic signed [COEF_W-1:0] RST_CAL_YO  = -32'sd2645884;
   localparam logic [DIV_W-1:0]         RST_CAL_DIV = 31'd65536;
   localparam logic [THR_W-1:0]         RST_THR     = 8'd3;

   localparam logic [COORD_W-1:0] COORD_MAX = 16'h7FFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;

   typedef enum logic [CMD_W-1:0] {
      CMD_RAW_X    = 2'd0,
      CMD_RAW_Y    = 2'd1,
      CMD_PRESSURE = 2'd2,
      CMD_SYNC     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_XX   = 3'd0,
      CSR_CAL_XY   = 3'd1,
      CSR_CAL_XO   = 3'd2,
      CSR_CAL_YX   = 3'd3,
      CSR_CAL_YY   = 3'd4,
      CSR_CAL_YO   = 3'd5,
      CSR_CAL_DIV  = 3'd6,
      CSR_MOVE_THR = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_ADD,
      ST_DINIT,
      ST_DIV,
      ST_FIN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take_raw;
      logic do_release;
      logic mul1;
      logic mul2;
      logic add;
      logic dinit;
      logic dstep;
      logic fin;
      logic axis;
      logic commit;
      logic load_out;
   } tecd_ctl_type;

   typedef struct packed {
      logic is_sync;
      logic releasing;
      logic drop;
      logic pressed;
      logic div_last;
      logic move;
      logic out_free;
   } tecd_sts_type;

endpackage

`default_nettype wire

@@ design/touch_event_calibrate_debounce.sv @@
// Top level of the touch event debounce and calibration block.
//
// Items enter on the req channel: req_tuser holds the event kind (raw X, raw Y,
// pressure or sync) and req_tdata the sample, event time and current time.
// Raw X, raw Y and pressure items are latched when taken and give no result.
// A sync item closes a frame; stale or debounced frames are dropped at once
// unless they release the pen, and a release frame goes to the emit state.
// A frame with pressure is mapped per axis by one shared multiplier (two products
// and an add), a divider setup step, a restoring divider that makes one quotient
// bit a cycle and a saturation step; the move decision follows, and only a point
// that moved goes to the emit state, which loads the output register and so raises
// rsp_tvalid once that register is free. The block takes one item at a time;
// req_tready is high only while idle, so the input waits until a frame is done.
// Results sit in an output register on the rsp channel, so the next item is
// taken while a result waits; a finished frame holds the controller, and so
// the input, while that register is full and rsp_tready is low.
// Settings are written on the csr channel, which is always ready.
// After reset all latched samples and positions are zero, the pen is up and the
// settings hold their default calibration.
`default_nettype none

`include "touch_event_calibrate_debounce_assert.svh"

module touch_event_calibrate_debounce (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tecd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tecd_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // sample [15:0], event_ms [47:16], now_ms [79:48]
   input  wire logic [tecd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd [1:0]
   input  wire logic [tecd_pkg::CMD_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // screen_x [15:0], screen_y [31:16]
   output logic [tecd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // button_down [0]
   output logic                                  rsp_tuser
);
   import tecd_pkg::*;

   tecd_ctl_type ctl;
   tecd_sts_type sts;

   assign csr_ready = 1'b1;

   tecd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   tecd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .ctl        (ctl),
      .sts        (sts)
   );

   `TECD_ASSERT_SAME(a_load_when_free, clock, reset, ctl.load_out, !rsp_tvalid || rsp_tready)
   `TECD_ASSERT_NEXT(a_load_shows_item, clock, reset, ctl.load_out, rsp_tvalid)
   `TECD_ASSERT_SAME(a_no_step_when_ready, clock, reset, req_tready, !ctl.dstep && !ctl.fin)
   `TECD_ASSERT_NEXT(a_raw_one_cycle, clock, reset,
      req_tvalid && req_tready && (req_tuser != CMD_SYNC), req_tready)

endmodule

`default_nettype wire

@@ design/tecd_dpath.sv @@
// Datapath: settings, latched samples, frame checks, multiplier, divider and output register.
`default_nettype none

module tecd_dpath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   input  wire logic [tecd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tecd_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic [tecd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [tecd_pkg::CMD_W-1:0]       req_tuser,
   input  wire logic                             rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [tecd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser,
   input  wire tecd_pkg::tecd_ctl_type           ctl,
   output tecd_pkg::tecd_sts_type                sts
);
   import tecd_pkg::*;

   logic signed [COEF_W-1:0] cal_xx_ff, cal_xy_ff, cal_xo_ff;
   logic signed [COEF_W-1:0] cal_yx_ff, cal_yy_ff, cal_yo_ff;
   logic [DIV_W-1:0]         cal_div_ff;
   logic [THR_W-1:0]         thr_ff;

   logic [RAW_BITS-1:0]  raw_x_ff, raw_y_ff, raw_p_ff;
   logic                 pen_down_ff;
   logic [COORD_W-1:0]   prev_x_ff, prev_y_ff, shown_x_ff, shown_y_ff;
   logic [TIME_BITS-1:0] release_ms_ff;

   logic [RAW_BITS-1:0]  sample;
   logic [TIME_BITS-1:0] event_ms, now_ms, age, gap;
   logic                 stale, bounce, releasing;

   logic signed [COEF_W-1:0] coef, offset;
   logic [RAW_BITS-1:0]      mraw;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic [ACC_W-1:0] mag;
   logic [DIV_W-1:0] div_eff;
   logic [REM_W-1:0] lim;
   logic             ovf;
   logic             neg_ff, ovf_ff;
   logic [REM_W-1:0] rem_ff, dsh_ff, rem_in;
   logic             ge;
   logic [QUO_W-1:0] q_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [COORD_W-1:0] coord, x_ff, y_ff;

   logic [COORD_W:0]   dx, dy, adx, ady;
   logic [DIST_W-1:0]  move_len;

   logic               rsp_valid_ff, rsp_btn_ff;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;

   assign sample   = req_tdata[RAW_BITS-1:0];
   assign event_ms = req_tdata[EVENT_LSB +: TIME_BITS];
   assign now_ms   = req_tdata[NOW_LSB +: TIME_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_xx_ff  <= RST_CAL_XX;
         cal_xy_ff  <= RST_CAL_XY;
         cal_xo_ff  <= RST_CAL_XO;
         cal_yx_ff  <= RST_CAL_YX;
         cal_yy_ff  <= RST_CAL_YY;
         cal_yo_ff  <= RST_CAL_YO;
         cal_div_ff <= RST_CAL_DIV;
         thr_ff     <= RST_THR;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAL_XX:   cal_xx_ff  <= $signed(csr_data);
            CSR_CAL_XY:   cal_xy_ff  <= $signed(csr_data);
            CSR_CAL_XO:   cal_xo_ff  <= $signed(csr_data);
            CSR_CAL_YX:   cal_yx_ff  <= $signed(csr_data);
            CSR_CAL_YY:   cal_yy_ff  <= $signed(csr_data);
            CSR_CAL_YO:   cal_yo_ff  <= $signed(csr_data);
            CSR_CAL_DIV:  cal_div_ff <= csr_data[DIV_W-1:0];
            CSR_MOVE_THR: thr_ff     <= csr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame checks on the item being offered.
   assign releasing = (raw_p_ff == '0) && pen_down_ff;
   assign age       = now_ms - event_ms;
   assign gap       = event_ms - release_ms_ff;
   assign stale     = !age[TIME_BITS-1] && (age >= TIME_BITS'(STALE_MS));
   assign bounce    = !gap[TIME_BITS-1] && (gap <= TIME_BITS'(DEBOUNCE_MS));

   assign sts.is_sync   = (cmd_type'(req_tuser) == CMD_SYNC);
   assign sts.releasing = releasing;
   assign sts.drop      = (stale || bounce) && !releasing;
   assign sts.pressed   = (raw_p_ff != '0);

   // Shared multiplier, one product a cycle.
   always_comb begin
      if (ctl.mul1) begin
         coef = ctl.axis ? cal_yx_ff : cal_xx_ff;
         mraw = raw_x_ff;
      end else begin
         coef = ctl.axis ? cal_yy_ff : cal_xy_ff;
         mraw = raw_y_ff;
      end
      offset = ctl.axis ? cal_yo_ff : cal_xo_ff;
   end

   assign prod_in = PROD_W'(coef) * PROD_W'($signed({1'b0, mraw}));

   // Divider front end: magnitude and quotient range check.
   assign mag     = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign div_eff = (cal_div_ff == '0) ? DIV_W'(1) : cal_div_ff;
   assign lim     = {div_eff, QUO_W'(0)};
   assign ovf     = (mag >= ACC_W'(lim));

   assign ge     = (rem_ff >= dsh_ff);
   assign rem_in = ge ? (rem_ff - dsh_ff) : rem_ff;
   assign sts.div_last = (cnt_ff == '0);

   always_comb begin
      if (ovf_ff) begin
         coord = neg_ff ? COORD_MIN : COORD_MAX;
      end else if (!neg_ff) begin
         coord = q_ff[QUO_W-1] ? COORD_MAX : q_ff;
      end else begin
         coord = (q_ff > COORD_MIN) ? COORD_MIN : COORD_W'(-q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul1 || ctl.mul2) begin
         prod_ff <= prod_in;
      end
      if (ctl.mul2) begin
         acc_ff <= ACC_W'(prod_ff) + ACC_W'(offset);
      end else if (ctl.add) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (ctl.dinit) begin
         neg_ff <= acc_ff[ACC_W-1];
         ovf_ff <= ovf;
         rem_ff <= REM_W'(mag);
         dsh_ff <= REM_W'({div_eff, (QUO_W - 1)'(0)});
         q_ff   <= '0;
         cnt_ff <= CNT_W'(QUO_W - 1);
      end else if (ctl.dstep) begin
         rem_ff <= rem_in;
         dsh_ff <= dsh_ff >> 1;
         q_ff   <= {q_ff[QUO_W-2:0], ge};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (ctl.fin) begin
         if (ctl.axis) begin
            y_ff <= coord;
         end else begin
            x_ff <= coord;
         end
      end
   end

   // Manhattan move from the last reported point.
   assign dx   = {prev_x_ff[COORD_W-1], prev_x_ff} - {x_ff[COORD_W-1], x_ff};
   assign dy   = {prev_y_ff[COORD_W-1], prev_y_ff} - {y_ff[COORD_W-1], y_ff};
   assign adx  = dx[COORD_W] ? (COORD_W + 1)'(-dx) : dx;
   assign ady  = dy[COORD_W] ? (COORD_W + 1)'(-dy) : dy;
   assign move_len = DIST_W'(adx) + DIST_W'(ady);
   assign sts.move = !pen_down_ff || (move_len > DIST_W'(thr_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_x_ff      <= '0;
         raw_y_ff      <= '0;
         raw_p_ff      <= '0;
         pen_down_ff   <= 1'b0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         shown_x_ff    <= '0;
         shown_y_ff    <= '0;
         release_ms_ff <= '0;
      end else begin
         if (ctl.take_raw) begin
            unique case (cmd_type'(req_tuser))
               CMD_RAW_X:    raw_x_ff <= sample;
               CMD_RAW_Y:    raw_y_ff <= sample;
               CMD_PRESSURE: raw_p_ff <= sample;
               default: ;
            endcase
         end
         if (ctl.do_release) begin
            release_ms_ff <= event_ms;
            pen_down_ff   <= 1'b0;
            prev_x_ff     <= '0;
            prev_y_ff     <= '0;
         end else if (ctl.commit) begin
            pen_down_ff <= 1'b1;
            prev_x_ff   <= x_ff;
            prev_y_ff   <= y_ff;
            shown_x_ff  <= x_ff;
            shown_y_ff  <= y_ff;
         end
      end
   end

   // Output register.
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_x_ff   <= shown_x_ff;
         rsp_y_ff   <= shown_y_ff;
         rsp_btn_ff <= pen_down_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_btn_ff;

endmodule

`default_nettype wire

@@ design/tecd_ctrl.sv @@
// Controller state machine that sequences frame checks, mapping and reporting.
`default_nettype none

module tecd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire tecd_pkg::tecd_sts_type sts,
   output tecd_pkg::tecd_ctl_type      ctl
);
   import tecd_pkg::*;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      req_tready = 1'b0;
      ctl        = '0;
      ctl.axis   = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (!sts.is_sync) begin
                  ctl.take_raw = 1'b1;
               end else if (!sts.drop) begin
                  if (sts.releasing) begin
                     ctl.do_release = 1'b1;
                     state_in       = ST_EMIT;
                  end else if (sts.pressed) begin
                     axis_in  = 1'b0;
                     state_in = ST_MUL1;
                  end
               end
            end
         end
         ST_MUL1: begin
            ctl.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            ctl.mul2 = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            ctl.add  = 1'b1;
            state_in = ST_DINIT;
         end
         ST_DINIT: begin
            ctl.dinit = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            ctl.dstep = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            ctl.fin = 1'b1;
            if (axis_ff) begin
               state_in = ST_DECIDE;
            end else begin
               axis_in  = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_DECIDE: begin
            if (sts.move) begin
               ctl.commit = 1'b1;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               ctl.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

@@ sim/touch_event_calibrate_debounce_tb.sv @@
// Self-checking testbench for the touch event calibration and debounce block.
module touch_event_calibrate_debounce_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tecd_pkg::*;

   localparam int SETTLE_CYCLES  = 60;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      cmd_type     cmd;
      logic [15:0] sample;
      logic [31:0] event_ms;
      logic [31:0] now_ms;
   } touch_event_type;

   typedef struct {
      logic [15:0] x;
      logic [15:0] y;
      logic        down;
   } touch_report_type;

   typedef enum {
      PROFILE_EXTREME,
      PROFILE_FLAT,
      PROFILE_MODERATE,
      PROFILE_WILD,
      PROFILE_STOCK
   } settings_profile_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;

   touch_event_calibrate_debounce dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Shadow settings and touch state.
   int          k_xx, k_xy, k_xo, k_yx, k_yy, k_yo;
   logic [30:0] cal_div;
   logic [7:0]  move_thr;
   logic [15:0] held_x, held_y, held_p;
   bit          touching;
   int          anchor_x, anchor_y, shown_x, shown_y;
   logic [31:0] lift_ms;

   touch_event_type  event_queue[$];
   touch_report_type pending_reports[$];
   touch_event_type  on_wire;
   touch_report_type seen_want;
   logic [31:0]   setting_vals [8];
   logic [31:0]   stamp_ms;
   logic [15:0]   finger_x = 16'd1000, finger_y = 16'd1000;
   int            mismatches = 0;
   int            feed_pause = 0, feed_calm = 0;
   int            drain_pause = 0, drain_calm = 0, hold_left = 0;
   bit            hold_wanted = 1'b0, hold_taken = 1'b0;
   int            idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int ms_delta(logic [31:0] a, logic [31:0] b);
      return int'(a - b);
   endfunction

   function automatic int map_axis(int wx, int wy, int off);
      longint total, d, q;
      d = (cal_div == 0) ? 64'sd1 : longint'(cal_div);
      total = longint'(wx) * longint'(held_x) + longint'(wy) * longint'(held_y)
              + longint'(off);
      q = total / d;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return int'(q);
   endfunction

   function automatic int next_pause(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) calm = $urandom_range(20, 60);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic restore_defaults();
      k_xx = RST_CAL_XX;
      k_xy = RST_CAL_XY;
      k_xo = RST_CAL_XO;
      k_yx = RST_CAL_YX;
      k_yy = RST_CAL_YY;
      k_yo = RST_CAL_YO;
      cal_div = RST_CAL_DIV;
      move_thr = RST_THR;
      held_x = '0;
      held_y = '0;
      held_p = '0;
      touching = 1'b0;
      anchor_x = 0;
      anchor_y = 0;
      shown_x = 0;
      shown_y = 0;
      lift_ms = '0;
   endtask

   task automatic store_setting(csr_index_type idx, logic [31:0] v);
      case (idx)
         CSR_CAL_XX:   k_xx = int'(v);
         CSR_CAL_XY:   k_xy = int'(v);
         CSR_CAL_XO:   k_xo = int'(v);
         CSR_CAL_YX:   k_yx = int'(v);
         CSR_CAL_YY:   k_yy = int'(v);
         CSR_CAL_YO:   k_yo = int'(v);
         CSR_CAL_DIV:  cal_div = v[30:0];
         CSR_MOVE_THR: move_thr = v[7:0];
         default: ;
      endcase
   endtask

   // Updates the touch state for one accepted item and queues any report it causes.
   task automatic apply_touch_event(touch_event_type ev);
      bit lifting, keep;
      int age, gap, nx, ny, dx, dy;
      case (ev.cmd)
         CMD_RAW_X:    held_x = ev.sample;
         CMD_RAW_Y:    held_y = ev.sample;
         CMD_PRESSURE: held_p = ev.sample;
         default: begin
            lifting = (held_p == 0) && touching;
            age = ms_delta(ev.now_ms, ev.event_ms);
            gap = ms_delta(ev.event_ms, lift_ms);
            keep = lifting || !(age >= STALE_MS || (gap >= 0 && gap <= DEBOUNCE_MS));
            if (keep) begin
               if (lifting) lift_ms = ev.event_ms;
               if (held_p != 0) begin
                  nx = map_axis(k_xx, k_xy, k_xo);
                  ny = map_axis(k_yx, k_yy, k_yo);
                  dx = anchor_x - nx;
                  dy = anchor_y - ny;
                  if (dx < 0) dx = -dx;
                  if (dy < 0) dy = -dy;
                  if (!touching || dx + dy > int'(move_thr)) begin
                     anchor_x = nx;
                     anchor_y = ny;
                     shown_x = nx;
                     shown_y = ny;
                     touching = 1'b1;
                     pending_reports.push_back('{16'(nx), 16'(ny), 1'b1});
                  end
               end else if (touching) begin
                  pending_reports.push_back('{16'(shown_x), 16'(shown_y), 1'b0});
                  touching = 1'b0;
                  anchor_x = 0;
                  anchor_y = 0;
               end
            end
         end
      endcase
   endtask

   // Sender: offers queued items with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         feed_pause = 0;
      end else begin
         if (req_tvalid && req_tready) apply_touch_event(on_wire);
         if (!req_tvalid || req_tready) begin
            if (feed_pause > 0) begin
               feed_pause--;
               req_tvalid <= 1'b0;
            end else if (event_queue.size() > 0) begin
               on_wire = event_queue.pop_front();
               req_tdata <= {on_wire.now_ms, on_wire.event_ms, on_wire.sample};
               req_tuser <= on_wire.cmd;
               req_tvalid <= 1'b1;
               feed_pause = next_pause(feed_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each report and stalls at random, once for a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               $error("report with no expectation: x %0d y %0d button_down %0b",
                      $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]), rsp_tuser);
               mismatches++;
            end else begin
               seen_want = pending_reports.pop_front();
               if (rsp_tdata[15:0] !== seen_want.x) begin
                  $error("screen_x expected %0d got %0d", $signed(seen_want.x),
                         $signed(rsp_tdata[15:0]));
                  mismatches++;
               end
               if (rsp_tdata[31:16] !== seen_want.y) begin
                  $error("screen_y expected %0d got %0d", $signed(seen_want.y),
                         $signed(rsp_tdata[31:16]));
                  mismatches++;
               end
               if (rsp_tuser !== seen_want.down) begin
                  $error("button_down expected %0b got %0b", seen_want.down, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (drain_pause > 0) begin
            drain_pause--;
            rsp_tready <= 1'b0;
         end else begin
            drain_pause = next_pause(drain_calm);
            rsp_tready <= (drain_pause == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("touch_event_calibrate_debounce regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_event(cmd_type c, logic [15:0] s, logic [31:0] ev, logic [31:0] now);
      event_queue.push_back('{c, s, ev, now});
   endtask

   task automatic write_setting(csr_index_type idx, logic [31:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      store_setting(idx, v);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (event_queue.size() != 0 || req_tvalid || pending_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic choose_settings(settings_profile_type profile);
      logic [31:0] raw;
      case (profile)
         PROFILE_EXTREME: begin
            setting_vals[CSR_CAL_XX] = 32'h7FFF_FFFF;
            setting_vals[CSR_CAL_XY] = 32'h8000_0000;
            setting_vals[CSR_CAL_XO] = 32'h7FFF_FFFF;
            setting_vals[CSR_CAL_YX] = 32'h8000_0000;
            setting_vals[CSR_CAL_YY] = 32'h7FFF_FFFF;
            setting_vals[CSR_CAL_YO] = 32'h8000_0000;
            setting_vals[CSR_CAL_DIV] = 32'd1;
            setting_vals[CSR_MOVE_THR] = 32'd0;
         end
         PROFILE_FLAT: begin
            setting_vals[CSR_CAL_XX] = $urandom;
            setting_vals[CSR_CAL_XY] = $urandom;
            setting_vals[CSR_CAL_XO] = $urandom;
            setting_vals[CSR_CAL_YX] = $urandom;
            setting_vals[CSR_CAL_YY] = $urandom;
            setting_vals[CSR_CAL_YO] = $urandom;
            setting_vals[CSR_CAL_DIV] = 32'h7FFF_FFFF;
            setting_vals[CSR_MOVE_THR] = 32'd255;
         end
         PROFILE_MODERATE: begin
            setting_vals[CSR_CAL_XX] = $urandom_range(0, 60000) - 32'd30000;
            setting_vals[CSR_CAL_XY] = $urandom_range(0, 60000) - 32'd30000;
            setting_vals[CSR_CAL_XO] = $urandom_range(0, 8000000) - 32'd4000000;
            setting_vals[CSR_CAL_YX] = $urandom_range(0, 60000) - 32'd30000;
            setting_vals[CSR_CAL_YY] = $urandom_range(0, 60000) - 32'd30000;
            setting_vals[CSR_CAL_YO] = $urandom_range(0, 8000000) - 32'd4000000;
            setting_vals[CSR_CAL_DIV] = $urandom_range(1, 262144);
            setting_vals[CSR_MOVE_THR] = $urandom_range(0, 12);
         end
         PROFILE_WILD: begin
            setting_vals[CSR_CAL_XX] = $urandom;
            setting_vals[CSR_CAL_XY] = $urandom;
            setting_vals[CSR_CAL_XO] = $urandom;
            setting_vals[CSR_CAL_YX] = $urandom;
            setting_vals[CSR_CAL_YY] = $urandom;
            setting_vals[CSR_CAL_YO] = $urandom;
            raw = $urandom;
            setting_vals[CSR_CAL_DIV] = (raw[30:0] == 0) ? 32'd1 : {1'b0, raw[30:0]};
            setting_vals[CSR_MOVE_THR] = $urandom_range(0, 255);
         end
         default: begin
            setting_vals[CSR_CAL_XX] = RST_CAL_XX;
            setting_vals[CSR_CAL_XY] = RST_CAL_XY;
            setting_vals[CSR_CAL_XO] = RST_CAL_XO;
            setting_vals[CSR_CAL_YX] = RST_CAL_YX;
            setting_vals[CSR_CAL_YY] = RST_CAL_YY;
            setting_vals[CSR_CAL_YO] = RST_CAL_YO;
            setting_vals[CSR_CAL_DIV] = {1'b0, RST_CAL_DIV};
            setting_vals[CSR_MOVE_THR] = $urandom_range(0, 6);
         end
      endcase
      for (int i = 0; i < 8; i++) write_setting(csr_index_type'(i), setting_vals[i]);
   endtask

   // Mostly complete frames around a wandering finger, with partial frames and noise.
   task automatic add_random_events(int count);
      int added, pick;
      logic [31:0] ev, now;
      logic [15:0] rx, ry, pr;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 99) < 82) begin
            pick = $urandom_range(0, 99);
            stamp_ms = stamp_ms + ((pick < 12) ? $urandom_range(0, 80) : $urandom_range(1, 150));
            ev = stamp_ms;
            pick = $urandom_range(0, 99);
            if (pick < 84) now = ev + $urandom_range(0, 40);
            else if (pick < 90) now = ev + $urandom_range(995, 1005);
            else if (pick < 95) now = ev + $urandom;
            else now = ev - $urandom_range(1, 2000);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               finger_x = 16'($urandom_range(150, 2700));
               finger_y = 16'($urandom_range(300, 2700));
            end
            if (pick < 75) begin
               rx = finger_x + 16'($urandom_range(0, 8)) - 16'd4;
               ry = finger_y + 16'($urandom_range(0, 8)) - 16'd4;
            end else begin
               rx = 16'($urandom);
               ry = 16'($urandom);
            end
            pr = ($urandom_range(0, 99) < 18) ? 16'd0 : 16'($urandom_range(1, 65535));
            pick = $urandom_range(0, 99);
            if (pick >= 8) begin
               add_event(CMD_RAW_X, rx, ev, now);
               added++;
            end
            if (pick < 8 || pick >= 16) begin
               add_event(CMD_RAW_Y, ry, ev, now);
               added++;
            end
            add_event(CMD_PRESSURE, pr, ev, now);
            add_event(CMD_SYNC, 16'($urandom), ev, now);
            added += 2;
         end else begin
            add_event(cmd_type'($urandom_range(0, 3)), 16'($urandom), $urandom, $urandom);
            added++;
         end
      end
   endtask

   task automatic run_phase(settings_profile_type profile, int count);
      choose_settings(profile);
      stamp_ms = $urandom;
      add_random_events(count);
      wait_drained();
   endtask

   initial begin
      restore_defaults();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Idle frame with the pen up.
      add_event(CMD_SYNC, 16'h0000, 32'd5000, 32'd5010);
      // First press, mapped to negative coordinates.
      add_event(CMD_RAW_X, 16'h0000, 32'd100, 32'd100);
      add_event(CMD_RAW_Y, 16'h0000, 32'd100, 32'd100);
      add_event(CMD_PRESSURE, 16'hFFFF, 32'd100, 32'd100);
      add_event(CMD_SYNC, 16'hFFFF, 32'd100, 32'd100);
      // Large move just short of the age limit.
      add_event(CMD_RAW_X, 16'hFFFF, 32'd200, 32'd1199);
      add_event(CMD_RAW_Y, 16'hFFFF, 32'd200, 32'd1199);
      add_event(CMD_SYNC, 16'h0000, 32'd200, 32'd1199);
      // Stale frame at exactly the age limit.
      add_event(CMD_SYNC, 16'h0000, 32'd300, 32'd1300);
      // Move below the threshold.
      add_event(CMD_RAW_X, 16'hFFFE, 32'd400, 32'd400);
      add_event(CMD_SYNC, 16'h0000, 32'd400, 32'd400);
      // Event stamped in the future is not stale.
      add_event(CMD_RAW_X, 16'h8000, 32'd500, 32'd450);
      add_event(CMD_SYNC, 16'h0000, 32'd500, 32'd450);
      // Release is kept even when stale.
      add_event(CMD_PRESSURE, 16'h0000, 32'd600, 32'd5000);
      add_event(CMD_SYNC, 16'h0000, 32'd600, 32'd5000);
      // Press at the edge of the debounce window is dropped, one later is kept.
      add_event(CMD_PRESSURE, 16'h1234, 32'd670, 32'd670);
      add_event(CMD_SYNC, 16'h0000, 32'd670, 32'd670);
      add_event(CMD_SYNC, 16'h0000, 32'd671, 32'd680);
      // Release and press across the wrap of the millisecond counter.
      add_event(CMD_PRESSURE, 16'h0000, 32'hFFFF_FFF0, 32'h0000_0010);
      add_event(CMD_SYNC, 16'h0000, 32'hFFFF_FFF0, 32'h0000_0010);
      add_event(CMD_PRESSURE, 16'h0005, 32'hFFFF_FFE0, 32'h0000_0010);
      add_event(CMD_SYNC, 16'h0000, 32'hFFFF_FFE0, 32'h0000_0010);
      add_event(CMD_SYNC, 16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      wait_drained();

      hold_wanted = 1'b1;
      stamp_ms = $urandom;
      add_random_events(220);
      wait_drained();

      run_phase(PROFILE_EXTREME, 220);
      run_phase(PROFILE_FLAT, 150);
      run_phase(PROFILE_MODERATE, 230);
      run_phase(PROFILE_WILD, 200);
      run_phase(PROFILE_STOCK, 120);

      if (pending_reports.size() != 0) begin
         $error("%0d expected reports never arrived", pending_reports.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("touch_event_calibrate_debounce regression: pass");
      end else begin
         $display("touch_event_calibrate_debounce regression: fail");
      end
      $finish;
   end

endmodule
